/* hdl/qau_pkg.sv */
// Shared types, widths, operation codes and saturation helpers for the quaternion unit.
package qau_pkg;

  localparam int DW   = 32;                // component width
  localparam int FB   = 16;                // fraction bits
  localparam int PW   = 2 * DW;            // product width
  localparam int SUMW = 2 * DW + 2;        // sum of four products
  localparam int SSW  = 2 * DW + 1;        // squared norm
  localparam int NW   = DW + FB;           // dividend and quotient width
  localparam int DENW = 2 * DW + 1 - FB;   // divisor width
  localparam int RMW  = DW + 3;            // square root remainder width
  localparam int THW  = 31;                // threshold register width

  localparam logic [2:0] KIND_MUL  = 3'd0;
  localparam logic [2:0] KIND_ROT  = 3'd1;
  localparam logic [2:0] KIND_NORM = 3'd2;
  localparam logic [2:0] KIND_INV  = 3'd3;
  localparam logic [2:0] KIND_CONJ = 3'd4;

  typedef logic signed [DW-1:0] fx_t;

  localparam fx_t SMAX   = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t SMIN   = {1'b1, {(DW-1){1'b0}}};
  localparam fx_t ONE_FX = fx_t'(1) <<< FB;

  typedef struct packed {
    logic [2:0]     kind;
    fx_t [3:0]      r;
    logic           sat;
    logic [SSW-1:0] ss;
  } front_t;

  typedef struct packed {
    fx_t [3:0] r;
    logic      deg;
    logic      sat;
  } res_t;

  function automatic logic is_ovf(input logic signed [SUMW-1:0] v);
    return (v > SUMW'(SMAX)) || (v < SUMW'(SMIN));
  endfunction

  function automatic fx_t sat_fx(input logic signed [SUMW-1:0] v);
    if (v > SUMW'(SMAX)) begin
      return SMAX;
    end else if (v < SUMW'(SMIN)) begin
      return SMIN;
    end
    return fx_t'(v[DW-1:0]);
  endfunction

endpackage

/* hdl/qau_front.sv */
// Product, sum and rotation stages; early results for multiply, rotate and conjugate.
module qau_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0]             in_kind,
  input  qau_pkg::fx_t [3:0]     in_a,
  input  qau_pkg::fx_t [3:0]     in_b,
  output logic                   out_valid,
  output qau_pkg::front_t        out_data
);
  import qau_pkg::*;

  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [SUMW-1:0] sum_t;

  logic           va, vb, vc, vd;
  logic [2:0]     ka, kb, kc, kd;
  fx_t [3:0]      aa, ba, ab, bb, ac, bc, ad, bd;
  prod_t          p [4][4];
  sum_t           ms [4];
  fx_t [2:0]      tc;
  logic           tsc, tsd;
  logic [SSW-1:0] ssc, ssd;
  fx_t [3:0]      erd;
  logic           esd;
  prod_t          rp [3][3];

  logic           use_sq;
  sum_t           md [4];
  sum_t           td [3];
  sum_t           sss;
  fx_t [2:0]      tv;
  logic [2:0]     tov;
  fx_t [3:0]      mr, cr;
  logic [3:0]     mo, co;
  sum_t           rs [3];
  fx_t [2:0]      rr;
  logic [2:0]     ro;
  front_t         fo;

  assign use_sq = (in_kind == KIND_NORM) || (in_kind == KIND_INV);

  always_comb begin
    md[0] = sum_t'(p[0][0]) - sum_t'(p[1][1]) - sum_t'(p[2][2]) - sum_t'(p[3][3]);
    md[1] = sum_t'(p[0][1]) + sum_t'(p[1][0]) + sum_t'(p[2][3]) - sum_t'(p[3][2]);
    md[2] = sum_t'(p[0][2]) - sum_t'(p[1][3]) + sum_t'(p[2][0]) + sum_t'(p[3][1]);
    md[3] = sum_t'(p[0][3]) + sum_t'(p[1][2]) - sum_t'(p[2][1]) + sum_t'(p[3][0]);
    td[0] = (sum_t'(p[2][3]) - sum_t'(p[3][2])) >>> (FB - 1);
    td[1] = (sum_t'(p[3][1]) - sum_t'(p[1][3])) >>> (FB - 1);
    td[2] = (sum_t'(p[1][2]) - sum_t'(p[2][1])) >>> (FB - 1);
    sss   = sum_t'(p[0][0]) + sum_t'(p[1][1]) + sum_t'(p[2][2]) + sum_t'(p[3][3]);
    for (int i = 0; i < 3; i++) begin
      tv[i]  = sat_fx(td[i]);
      tov[i] = is_ovf(td[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mr[i] = sat_fx(ms[i] >>> FB);
      mo[i] = is_ovf(ms[i] >>> FB);
    end
    cr[0] = ac[0];
    co[0] = 1'b0;
    for (int i = 1; i < 4; i++) begin
      cr[i] = sat_fx(-sum_t'(ac[i]));
      co[i] = is_ovf(-sum_t'(ac[i]));
    end
  end

  always_comb begin
    rs[0] = (sum_t'(bd[1]) <<< FB) + sum_t'(rp[0][0]) + sum_t'(rp[0][1]) - sum_t'(rp[0][2]);
    rs[1] = (sum_t'(bd[2]) <<< FB) + sum_t'(rp[1][0]) + sum_t'(rp[1][1]) - sum_t'(rp[1][2]);
    rs[2] = (sum_t'(bd[3]) <<< FB) + sum_t'(rp[2][0]) + sum_t'(rp[2][1]) - sum_t'(rp[2][2]);
    for (int i = 0; i < 3; i++) begin
      rr[i] = sat_fx(rs[i] >>> FB);
      ro[i] = is_ovf(rs[i] >>> FB);
    end
    fo.kind = kd;
    fo.ss   = ssd;
    unique case (kd) inside
      KIND_MUL, KIND_CONJ: begin
        fo.r   = erd;
        fo.sat = esd;
      end
      KIND_ROT: begin
        fo.r   = {rr[2], rr[1], rr[0], fx_t'(0)};
        fo.sat = tsd | (|ro);
      end
      KIND_NORM, KIND_INV: begin
        fo.r   = ad;
        fo.sat = 1'b0;
      end
      default: begin
        fo.r   = '0;
        fo.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      out_valid <= vd;
    end
    if (en) begin
      ka <= in_kind;
      aa <= in_a;
      ba <= use_sq ? in_a : in_b;

      kb <= ka;
      ab <= aa;
      bb <= ba;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p[i][j] <= prod_t'(aa[i]) * prod_t'(ba[j]);
        end
      end

      kc  <= kb;
      ac  <= ab;
      bc  <= bb;
      ms  <= md;
      tc  <= tv;
      tsc <= |tov;
      ssc <= sss[SSW-1:0];

      kd  <= kc;
      ad  <= ac;
      bd  <= bc;
      tsd <= tsc;
      ssd <= ssc;
      erd <= (kc == KIND_CONJ) ? cr : mr;
      esd <= (kc == KIND_CONJ) ? (|co) : (|mo);
      rp[0][0] <= prod_t'(ac[0]) * prod_t'(tc[0]);
      rp[0][1] <= prod_t'(ac[2]) * prod_t'(tc[2]);
      rp[0][2] <= prod_t'(ac[3]) * prod_t'(tc[1]);
      rp[1][0] <= prod_t'(ac[0]) * prod_t'(tc[1]);
      rp[1][1] <= prod_t'(ac[3]) * prod_t'(tc[0]);
      rp[1][2] <= prod_t'(ac[1]) * prod_t'(tc[2]);
      rp[2][0] <= prod_t'(ac[0]) * prod_t'(tc[2]);
      rp[2][1] <= prod_t'(ac[1]) * prod_t'(tc[1]);
      rp[2][2] <= prod_t'(ac[2]) * prod_t'(tc[0]);

      out_data <= fo;
    end
  end

endmodule

/* hdl/qau_sqrt.sv */
// Pipelined floor square root of the squared norm, one root bit per stage.
module qau_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  qau_pkg::front_t     in_data,
  output logic                out_valid,
  output qau_pkg::front_t     out_data,
  output logic [qau_pkg::DW-1:0] out_root
);
  import qau_pkg::*;

  logic            v    [DW];
  front_t          pl   [DW];
  logic [RMW-1:0]  rem  [DW];
  logic [DW-1:0]   root [DW];
  logic [2*DW-1:0] rad  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic            v_i;
    front_t          pl_i;
    logic [RMW-1:0]  rem_i, rem_sh, trial;
    logic [DW-1:0]   root_i;
    logic [2*DW-1:0] rad_i;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign pl_i   = in_data;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_data.ss[2*DW-1:0];
    end else begin : g_next
      assign v_i    = v[k-1];
      assign pl_i   = pl[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign rad_i  = rad[k-1];
    end

    assign rem_sh = {rem_i[RMW-3:0], rad_i[2*DW-1 -: 2]};
    assign trial  = RMW'({root_i, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_i;
      end
      if (en) begin
        pl[k]   <= pl_i;
        rem[k]  <= ge ? rem_sh - trial : rem_sh;
        root[k] <= {root_i[DW-2:0], ge};
        rad[k]  <= rad_i << 2;
      end
    end
  end

  assign out_valid = v[DW-1];
  assign out_data  = pl[DW-1];
  assign out_root  = root[DW-1];

endmodule

/* hdl/qau_div.sv */
// Threshold check and pipelined restoring divider for normalize and inverse; final select.
module qau_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [qau_pkg::THW-1:0] thr,
  input  logic                    in_valid,
  input  qau_pkg::front_t         in_data,
  input  logic [qau_pkg::DW-1:0]  in_root,
  output logic                    out_valid,
  output qau_pkg::res_t           out_data
);
  import qau_pkg::*;

  typedef struct packed {
    logic [2:0]      kind;
    fx_t [3:0]       r;
    logic            sat;
    logic            deg;
    logic [3:0]      neg;
    logic [DENW-1:0] den;
  } hdr_t;

  logic                   v0;
  hdr_t                   h0;
  logic [3:0][NW-1:0]     nq0;
  logic                   v   [NW];
  hdr_t                   h   [NW];
  logic [3:0][DENW-1:0]   rem [NW];
  logic [3:0][NW-1:0]     nq  [NW];

  hdr_t                   hc;
  logic [3:0][NW-1:0]     nqc;
  logic [DW-1:0]          mg;
  logic                   flip;
  res_t                   rc;
  logic [NW-1:0]          q;
  logic [DW-1:0]          ql;
  logic [3:0]             qo;
  fx_t [3:0]              qr;

  always_comb begin
    hc.kind = in_data.kind;
    hc.r    = in_data.r;
    hc.sat  = in_data.sat;
    if (in_data.kind == KIND_NORM) begin
      hc.den = in_data.ss[SSW-1] ? (DENW'(1) << DW) : DENW'(in_root);
    end else begin
      hc.den = in_data.ss[SSW-1:FB];
    end
    hc.deg = hc.den <= DENW'(thr);
    for (int l = 0; l < 4; l++) begin
      flip       = (in_data.kind == KIND_INV) && (l != 0);
      mg         = in_data.r[l][DW-1] ? (~in_data.r[l]) + DW'(1) : in_data.r[l];
      hc.neg[l]  = flip ? (!in_data.r[l][DW-1] && (in_data.r[l] != '0))
                        : in_data.r[l][DW-1];
      nqc[l]     = {mg, {FB{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      h0  <= hc;
      nq0 <= nqc;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic                 v_i;
    hdr_t                 h_i;
    logic [3:0][DENW-1:0] rem_i, rem_o;
    logic [3:0][NW-1:0]   nq_i, nq_o;
    logic [DENW:0]        rs, df;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_i   = v0;
      assign h_i   = h0;
      assign rem_i = '0;
      assign nq_i  = nq0;
    end else begin : g_next
      assign v_i   = v[k-1];
      assign h_i   = h[k-1];
      assign rem_i = rem[k-1];
      assign nq_i  = nq[k-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rs       = {rem_i[l], nq_i[l][NW-1]};
        df       = rs - {1'b0, h_i.den};
        ge       = rs >= {1'b0, h_i.den};
        rem_o[l] = ge ? df[DENW-1:0] : rs[DENW-1:0];
        nq_o[l]  = {nq_i[l][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_i;
      end
      if (en) begin
        h[k]   <= h_i;
        rem[k] <= rem_o;
        nq[k]  <= nq_o;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      q  = nq[NW-1][l];
      ql = q[DW-1:0];
      if (h[NW-1].neg[l]) begin
        qo[l] = q > (NW'(1) << (DW - 1));
        qr[l] = qo[l] ? SMIN : fx_t'(DW'(0) - ql);
      end else begin
        qo[l] = q > NW'(SMAX);
        qr[l] = qo[l] ? SMAX : fx_t'(ql);
      end
    end
    unique case (h[NW-1].kind) inside
      KIND_NORM, KIND_INV: begin
        if (h[NW-1].deg) begin
          rc.r   = {fx_t'(0), fx_t'(0), fx_t'(0), ONE_FX};
          rc.deg = 1'b1;
          rc.sat = 1'b0;
        end else begin
          rc.r   = qr;
          rc.deg = 1'b0;
          rc.sat = |qo;
        end
      end
      default: begin
        rc.r   = h[NW-1].r;
        rc.deg = 1'b0;
        rc.sat = h[NW-1].sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NW-1];
    end
    if (en) begin
      out_data <= rc;
    end
  end

endmodule

/* hdl/quaternion_arithmetic_unit.sv */
// Quaternion arithmetic unit: fully pipelined, one transfer per cycle while input
// ready is high; the whole pipeline stalls while it is low. Most of the depth
// comes from the 32-stage square root followed by the 48-stage divider; every
// operation takes the same path so results leave in input order. A two-entry
// output buffer decouples the stream sides; input ready drops only when both
// entries hold results.
module quaternion_arithmetic_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [qau_pkg::THW-1:0]   cfg_wdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [8*qau_pkg::DW-1:0]  s_axis_tdata,
  // kind
  input  logic [2:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // r_w, r_x, r_y, r_z
  output logic [4*qau_pkg::DW-1:0]  m_axis_tdata,
  // degenerate, saturated
  output logic [1:0]                m_axis_tuser
);
  import qau_pkg::*;

  logic [THW-1:0] zero_threshold;
  logic           en;
  fx_t [3:0]      in_a, in_b;
  logic           fr_valid, sq_valid, dv_valid;
  front_t         fr_data, sq_data;
  logic [DW-1:0]  sq_root;
  res_t           dv_data;
  logic           push, pop;
  logic           head_valid, skid_valid;
  res_t           head, skid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign in_a          = s_axis_tdata[4*DW-1:0];
  assign in_b          = s_axis_tdata[8*DW-1:4*DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= '0;
    end else if (cfg_we) begin
      zero_threshold <= cfg_wdata;
    end
  end

  qau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_a      (in_a),
    .in_b      (in_b),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  qau_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .out_valid (sq_valid),
    .out_data  (sq_data),
    .out_root  (sq_root)
  );

  qau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .thr       (zero_threshold),
    .in_valid  (sq_valid),
    .in_data   (sq_data),
    .in_root   (sq_root),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  assign push = en && dv_valid;
  assign pop  = head_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
    if (pop && skid_valid) begin
      head <= skid;
    end else if (push && (pop || !head_valid)) begin
      head <= dv_data;
    end
    if (push && head_valid && !pop) begin
      skid <= dv_data;
    end
  end

  assign m_axis_tvalid = head_valid;
  assign m_axis_tdata  = head.r;
  assign m_axis_tuser  = {head.sat, head.deg};

endmodule

/* hdl/qau_checker.sv */
// Port-level checks for the quaternion unit and their bind to the top level.
module qau_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [4*qau_pkg::DW-1:0] m_axis_tdata,
  input logic [1:0]               m_axis_tuser
);
  import qau_pkg::*;

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      !m_axis_tuser[1] && (m_axis_tdata == {{(3*DW){1'b0}}, ONE_FX}))
    else $error("degenerate result is not identity");

  a_ready_after_pop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready)
    else $error("input blocked after output transfer");

  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with no result pending");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
